/* hdl/assert_macros.svh */
// Assertion macros used by keyboard_port_interface_core. Defining NO_ASSERTIONS removes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed: invariant violated");

// Whenever the antecedent holds, the consequent holds at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/kpi_pkg.sv */
`default_nettype none

package kpi_pkg;

	// Command codes of an input transaction.
	localparam logic [2:0] CMD_PORTB_WR = 3'd0;
	localparam logic [2:0] CMD_PORTA_RD = 3'd1;
	localparam logic [2:0] CMD_PORTC_RD = 3'd2;
	localparam logic [2:0] CMD_KBD_CLK  = 3'd3;
	localparam logic [2:0] CMD_KBD_DATA = 3'd4;

	// Bit positions in the port B control latch.
	localparam int CTL_CLEAR  = 7;
	localparam int CTL_KCLK   = 6;
	localparam int CTL_NIBBLE = 3;
	localparam int CTL_SPK    = 1;
	localparam int CTL_GATE   = 0;

	localparam logic [7:0] EQUIP_RESET = 8'd125;

	typedef struct packed {
		logic [7:0] control_latch;
		logic [7:0] scan_shift;
		logic       shift_armed;
		logic       clock_seen;
		logic       data_seen;
		logic       irq_flag;
	} kpi_state_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] write_data;
		logic       line_level;
		logic       timer2_out;
	} kpi_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq1_level;
		logic       keyboard_clock_out;
		logic       keyboard_data_out;
		logic       timer2_gate;
		logic       speaker_level;
	} kpi_result_t;

endpackage

`default_nettype wire

/* hdl/kpi_if.sv */
`default_nettype none

interface kpi_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] write_data;
	logic       line_level;
	logic       timer2_out;

	modport source (output valid, command, write_data, line_level, timer2_out, input ready);
	modport sink (input valid, command, write_data, line_level, timer2_out, output ready);
endinterface

interface kpi_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq1_level;
	logic       keyboard_clock_out;
	logic       keyboard_data_out;
	logic       timer2_gate;
	logic       speaker_level;

	modport source (output valid, read_data, irq1_level, keyboard_clock_out,
		keyboard_data_out, timer2_gate, speaker_level, input ready);
	modport sink (input valid, read_data, irq1_level, keyboard_clock_out,
		keyboard_data_out, timer2_gate, speaker_level, output ready);
endinterface

interface kpi_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/keyboard_port_interface_core.sv */
// An accepted transaction passes the input register and then the result register on its
// way to the output channel. Throughput: one transaction per cycle while the output is
// not stalled; port state updates in the single cycle an item enters the result register.
// Reset (arst_n low, asynchronous): all port state clears to zero, the equipment
// switches return to 125 and both pipeline stages are emptied.
`default_nettype none
`include "assert_macros.svh"

module keyboard_port_interface_core
	import kpi_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	kpi_item_if.sink      item,
	kpi_result_if.source  result,
	kpi_cfg_if.sink       cfg
);

	logic        valid_s1;
	kpi_item_t   item_s1;
	logic        valid_s2;
	kpi_result_t result_s2;
	kpi_state_t  state_q;
	kpi_state_t  state_next;
	kpi_result_t result_next;
	logic [7:0]  switches_q;
	logic        adv_s1;
	logic        free_s2;

	assign free_s2 = !valid_s2 || result.ready;
	assign adv_s1 = valid_s1 && free_s2;
	assign item.ready = !valid_s1 || adv_s1;
	assign cfg.ready = 1'b1;

	kpi_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.switches   (switches_q),
		.next_state (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= '0;
			switches_q <= EQUIP_RESET;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_next;
			end
			if (cfg.valid) begin
				switches_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.command <= item.command;
			item_s1.write_data <= item.write_data;
			item_s1.line_level <= item.line_level;
			item_s1.timer2_out <= item.timer2_out;
		end
		if (adv_s1) begin
			result_s2 <= result_next;
		end
	end

	assign result.valid = valid_s2;
	assign result.read_data = result_s2.read_data;
	assign result.irq1_level = result_s2.irq1_level;
	assign result.keyboard_clock_out = result_s2.keyboard_clock_out;
	assign result.keyboard_data_out = result_s2.keyboard_data_out;
	assign result.timer2_gate = result_s2.timer2_gate;
	assign result.speaker_level = result_s2.speaker_level;

	// A pending interrupt and an armed shift register exclude each other.
	`ASSERT_ALWAYS(a_irq_disarms, clk, arst_n, !(state_q.irq_flag && state_q.shift_armed))
	// A transaction leaving the input register always lands in the result register.
	`ASSERT_NEXT(a_s1_to_s2, clk, arst_n, adv_s1, valid_s2)
	// The port state only changes when a transaction is processed.
	`ASSERT_NEXT(a_state_hold, clk, arst_n, !adv_s1, state_q == $past(state_q))

endmodule

`default_nettype wire

/* hdl/kpi_step.sv */
`default_nettype none

module kpi_step
	import kpi_pkg::*;
(
	input  wire kpi_state_t  state,
	input  wire kpi_item_t   item,
	input  wire [7:0]        switches,
	output kpi_state_t       next_state,
	output kpi_result_t      result
);

	logic [7:0] port_c;

	always_comb begin
		port_c = 8'h00;
		port_c[3:0] = state.control_latch[CTL_NIBBLE] ? switches[7:4] : switches[3:0];
		port_c[5] = item.timer2_out;
		// Bit 4 reads low only when the gate is on and the timer output is low.
		port_c[4] = ~(state.control_latch[CTL_GATE] & ~item.timer2_out);
	end

	always_comb begin
		next_state = state;
		result.read_data = 8'h00;
		case (item.command)
			CMD_PORTB_WR: begin
				next_state.control_latch = item.write_data;
				next_state.clock_seen = item.write_data[CTL_KCLK];
				if (item.write_data[CTL_CLEAR]) begin
					next_state.irq_flag = 1'b0;
					next_state.scan_shift = 8'h00;
					next_state.shift_armed = 1'b1;
				end
			end
			CMD_PORTA_RD: begin
				result.read_data = state.control_latch[CTL_CLEAR] ? switches : state.scan_shift;
			end
			CMD_PORTC_RD: begin
				result.read_data = port_c;
			end
			CMD_KBD_CLK: begin
				if ((item.line_level != state.clock_seen) && state.control_latch[CTL_KCLK]
						&& state.shift_armed) begin
					next_state.clock_seen = item.line_level;
					if (!state.control_latch[CTL_CLEAR] && !item.line_level) begin
						next_state.scan_shift = {state.data_seen, state.scan_shift[7:1]};
						// The start bit leaving the register ends the frame.
						if (state.scan_shift[0]) begin
							next_state.irq_flag = 1'b1;
							next_state.shift_armed = 1'b0;
							next_state.clock_seen = 1'b0;
						end
					end
				end
			end
			CMD_KBD_DATA: begin
				next_state.data_seen = item.line_level;
			end
			default: begin
			end
		endcase
		result.irq1_level = next_state.irq_flag;
		result.keyboard_clock_out = next_state.clock_seen;
		result.keyboard_data_out = next_state.data_seen;
		result.timer2_gate = next_state.control_latch[CTL_GATE];
		result.speaker_level = next_state.control_latch[CTL_SPK] & item.timer2_out;
	end

endmodule

`default_nettype wire
